FILE: rtl/core/cpct_pkg.sv
// Shared constants for the collider pair contact tracker: default sizes,
// shape kinds, pair classes and contact event codes. No dependencies.
`default_nettype none

package cpct_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_COLLIDERS_DEF = 64;
    localparam int COORD_WIDTH_DEF   = 16;

    // Collider ids arrive as fixed 6-bit fields.
    localparam int ID_WIDTH = 6;
    localparam int ID_COUNT = 2 ** ID_WIDTH;

    // Shape kinds carried in tuser.
    localparam logic KIND_RECT   = 1'b0;
    localparam logic KIND_CIRCLE = 1'b1;

    // Which overlap test a pair takes.
    localparam logic [1:0] PAIR_RR = 2'd0;
    localparam logic [1:0] PAIR_CC = 2'd1;
    localparam logic [1:0] PAIR_CR = 2'd2;

    // Contact event codes reported with each result.
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_STAY  = 2'd2;
    localparam logic [1:0] EV_EXIT  = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/cpct_touch_mem.sv
// One-bit-per-pair touching memory with a clearing pass after reset.
// Depends on cpct_pkg for the default collider count.
`default_nettype none

module cpct_touch_mem #(
    parameter int MAX_COLLIDERS = cpct_pkg::MAX_COLLIDERS_DEF,
    localparam int Depth = MAX_COLLIDERS * MAX_COLLIDERS,
    localparam int AddrWidth = $clog2(Depth)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_en,
    input  wire logic [AddrWidth-1:0] i_rd_addr,
    output logic                      o_rd_data,
    input  wire logic                 i_wr_en,
    input  wire logic [AddrWidth-1:0] i_wr_addr,
    input  wire logic                 i_wr_data,
    output logic                      o_busy
);

    logic                 r_mem [Depth];
    logic                 r_rd_data;
    logic                 r_busy;
    logic [AddrWidth-1:0] r_clr_addr;

    logic                 wr_en;
    logic [AddrWidth-1:0] wr_addr;
    logic                 wr_data;

    // The clearing pass owns the write port until every entry is zero.
    assign wr_en   = r_busy || i_wr_en;
    assign wr_addr = r_busy ? r_clr_addr : i_wr_addr;
    assign wr_data = r_busy ? 1'b0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AddrWidth'(Depth - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

FILE: rtl/core/collider_pair_contact_tracker_top.sv
// Top level of the collider pair contact tracker: the five-stage overlap
// test pipeline and the contact event logic. Depends on cpct_pkg and cpct_touch_mem.
`default_nettype none

// Each input transfer carries one ordered pair of colliders (ids, kinds,
// centres and extents) and yields exactly one output transfer with the
// overlap bit and a contact event (none, enter, stay or exit) judged
// against a touching bit kept for that ordered pair. The block takes one
// pair every clock cycle while the output side keeps taking results and the
// touching memory is not being cleared. On the way the pair passes five
// registers: an input register, a difference and bound stage, a magnitude
// and clamp stage, a squaring stage and the output register. The touching
// memory reads the bit of the pair entering the squaring stage while the
// pair leaving that stage writes its own bit on a separate port, so the
// read-modify-write needs no stall. A pair repeated back to back is served
// by forwarding the bit that is being written. Each stage holds its item
// only while the next one is full and stalled, so input transfers continue
// while a result waits to be taken, until every stage is full. After reset
// the touching memory is swept to zero one entry a cycle over all
// MAX_COLLIDERS * MAX_COLLIDERS entries (4096 at the default size), and the
// input side stays not ready during that pass. Ids not below MAX_COLLIDERS
// are reduced modulo MAX_COLLIDERS. All tests work on doubled coordinates,
// and the round tests on squared distances, so they are exact.
module collider_pair_contact_tracker_top #(
    parameter int MAX_COLLIDERS = cpct_pkg::MAX_COLLIDERS_DEF,
    parameter int COORD_WIDTH   = cpct_pkg::COORD_WIDTH_DEF,
    localparam int InWidth = ((2 * cpct_pkg::ID_WIDTH + 8 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Slave side.
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // tdata from bit 0 up: left_id, right_id, left_x, left_y, right_x,
    // right_y, left_width, left_height, right_width, right_height, zero fill.
    input  wire logic [InWidth-1:0] i_s_axis_tdata,
    // tuser from bit 0 up: left_kind, right_kind.
    input  wire logic [1:0]         i_s_axis_tuser,
    // Master side.
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    // tdata from bit 0 up: overlap, contact_event[1:0], zero fill.
    output logic [7:0]              o_m_axis_tdata
);

    localparam int W         = COORD_WIDTH;
    localparam int IdW       = cpct_pkg::ID_WIDTH;
    localparam int IdxW      = $clog2(MAX_COLLIDERS);
    localparam int AddrWidth = $clog2(MAX_COLLIDERS * MAX_COLLIDERS);
    localparam int MagW      = W + 2;
    localparam int LimW      = W + 1;
    localparam int SqW       = 2 * MagW;
    localparam int SqLimW    = 2 * LimW;

    localparam int OffLx = 2 * IdW;
    localparam int OffLy = OffLx + W;
    localparam int OffRx = OffLx + 2 * W;
    localparam int OffRy = OffLx + 3 * W;
    localparam int OffLw = OffLx + 4 * W;
    localparam int OffLh = OffLx + 5 * W;
    localparam int OffRw = OffLx + 6 * W;
    localparam int OffRh = OffLx + 7 * W;

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its successor moves.
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid;
    logic en_a, en_b, en_c, en_d, en_e;
    logic mem_busy;

    assign en_e = !r_e_valid || i_m_axis_tready;
    assign en_d = !r_d_valid || en_e;
    assign en_c = !r_c_valid || en_d;
    assign en_b = !r_b_valid || en_c;
    assign en_a = !r_a_valid || en_b;

    assign o_s_axis_tready = en_a && !mem_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_s_axis_tvalid && !mem_busy;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
            if (en_d) r_d_valid <= r_c_valid;
            if (en_e) r_e_valid <= r_d_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: the input register.
    // ------------------------------------------------------------------
    logic [InWidth-1:0] r_a_data;
    logic [1:0]         r_a_user;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_data <= i_s_axis_tdata;
            r_a_user <= i_s_axis_tuser;
        end
    end

    // Id reduction table: each 6-bit id maps to id modulo MAX_COLLIDERS.
    logic [IdxW-1:0] id_mod [cpct_pkg::ID_COUNT];

    for (genvar g = 0; g < cpct_pkg::ID_COUNT; g++) begin : g_id_mod
        localparam int ModVal = g % MAX_COLLIDERS;
        assign id_mod[g] = IdxW'(ModVal);
    end

    // ------------------------------------------------------------------
    // A to B: centre differences, extent sums, pair address and the
    // doubled rectangle bounds for the circle against rectangle test.
    // ------------------------------------------------------------------
    logic [IdW-1:0]      a_lid, a_rid;
    logic                a_lk, a_rk;
    logic signed [W-1:0] a_lx, a_ly, a_rx, a_ry;
    logic [W-1:0]        a_lw, a_lh, a_rw, a_rh;
    logic signed [W-1:0] a_cx, a_cy, a_qx, a_qy;
    logic [W-1:0]        a_cd, a_qw, a_qh;

    logic signed [W:0]   n_b_dx, n_b_dy;
    logic [W:0]          n_b_sw, n_b_sh;
    logic signed [W+1:0] n_b_px, n_b_py, n_b_lox, n_b_hix, n_b_loy, n_b_hiy;
    logic [1:0]          n_b_cls;
    logic [AddrWidth-1:0] n_b_addr;

    always_comb begin
        a_lid = r_a_data[0 +: IdW];
        a_rid = r_a_data[IdW +: IdW];
        a_lk  = r_a_user[0];
        a_rk  = r_a_user[1];
        a_lx  = r_a_data[OffLx +: W];
        a_ly  = r_a_data[OffLy +: W];
        a_rx  = r_a_data[OffRx +: W];
        a_ry  = r_a_data[OffRy +: W];
        a_lw  = r_a_data[OffLw +: W];
        a_lh  = r_a_data[OffLh +: W];
        a_rw  = r_a_data[OffRw +: W];
        a_rh  = r_a_data[OffRh +: W];

        n_b_addr = AddrWidth'(id_mod[a_lid] * MAX_COLLIDERS) + AddrWidth'(id_mod[a_rid]);

        n_b_dx = {a_lx[W-1], a_lx} - {a_rx[W-1], a_rx};
        n_b_dy = {a_ly[W-1], a_ly} - {a_ry[W-1], a_ry};
        n_b_sw = {1'b0, a_lw} + {1'b0, a_rw};
        n_b_sh = {1'b0, a_lh} + {1'b0, a_rh};

        if (a_lk == a_rk) begin
            n_b_cls = (a_lk == cpct_pkg::KIND_CIRCLE) ? cpct_pkg::PAIR_CC : cpct_pkg::PAIR_RR;
        end else begin
            n_b_cls = cpct_pkg::PAIR_CR;
        end

        // In a mixed pair, pick out which side is the circle.
        if (a_lk == cpct_pkg::KIND_CIRCLE) begin
            a_cx = a_lx;
            a_cy = a_ly;
            a_cd = a_lw;
            a_qx = a_rx;
            a_qy = a_ry;
            a_qw = a_rw;
            a_qh = a_rh;
        end else begin
            a_cx = a_rx;
            a_cy = a_ry;
            a_cd = a_rw;
            a_qx = a_lx;
            a_qy = a_ly;
            a_qw = a_lw;
            a_qh = a_lh;
        end

        n_b_px  = {a_cx[W-1], a_cx, 1'b0};
        n_b_py  = {a_cy[W-1], a_cy, 1'b0};
        n_b_lox = {a_qx[W-1], a_qx, 1'b0} - {2'b00, a_qw};
        n_b_hix = {a_qx[W-1], a_qx, 1'b0} + {2'b00, a_qw};
        n_b_loy = {a_qy[W-1], a_qy, 1'b0} - {2'b00, a_qh};
        n_b_hiy = {a_qy[W-1], a_qy, 1'b0} + {2'b00, a_qh};
    end

    logic signed [W:0]    r_b_dx, r_b_dy;
    logic [W:0]           r_b_sw, r_b_sh;
    logic signed [W+1:0]  r_b_px, r_b_py, r_b_lox, r_b_hix, r_b_loy, r_b_hiy;
    logic [W-1:0]         r_b_cd;
    logic [1:0]           r_b_cls;
    logic [AddrWidth-1:0] r_b_addr;

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_dx   <= n_b_dx;
            r_b_dy   <= n_b_dy;
            r_b_sw   <= n_b_sw;
            r_b_sh   <= n_b_sh;
            r_b_px   <= n_b_px;
            r_b_py   <= n_b_py;
            r_b_lox  <= n_b_lox;
            r_b_hix  <= n_b_hix;
            r_b_loy  <= n_b_loy;
            r_b_hiy  <= n_b_hiy;
            r_b_cd   <= a_cd;
            r_b_cls  <= n_b_cls;
            r_b_addr <= n_b_addr;
        end
    end

    // ------------------------------------------------------------------
    // B to C: the rectangle test, and the distance magnitudes and limit
    // that the two round tests square.
    // ------------------------------------------------------------------
    logic [W:0]        b_adx, b_ady, b_ex, b_ey;
    logic [MagW-1:0]   n_c_mx, n_c_my;
    logic [LimW-1:0]   n_c_lim;
    logic              n_c_rr, n_c_rrhit;

    always_comb begin
        b_adx = r_b_dx[W] ? (W+1)'(-r_b_dx) : (W+1)'(r_b_dx);
        b_ady = r_b_dy[W] ? (W+1)'(-r_b_dy) : (W+1)'(r_b_dy);

        // Strict overlap on both axes in doubled units.
        n_c_rrhit = ({b_adx, 1'b0} < {1'b0, r_b_sw}) && ({b_ady, 1'b0} < {1'b0, r_b_sh});

        // Distance from the doubled circle centre to the clamped point.
        if (r_b_px > r_b_hix) begin
            b_ex = (W+1)'(r_b_px - r_b_hix);
        end else if (r_b_px < r_b_lox) begin
            b_ex = (W+1)'(r_b_lox - r_b_px);
        end else begin
            b_ex = '0;
        end
        if (r_b_py > r_b_hiy) begin
            b_ey = (W+1)'(r_b_py - r_b_hiy);
        end else if (r_b_py < r_b_loy) begin
            b_ey = (W+1)'(r_b_loy - r_b_py);
        end else begin
            b_ey = '0;
        end

        unique case (r_b_cls)
            cpct_pkg::PAIR_CC: begin
                n_c_rr  = 1'b0;
                n_c_mx  = {b_adx, 1'b0};
                n_c_my  = {b_ady, 1'b0};
                n_c_lim = r_b_sw;
            end
            cpct_pkg::PAIR_CR: begin
                n_c_rr  = 1'b0;
                n_c_mx  = {1'b0, b_ex};
                n_c_my  = {1'b0, b_ey};
                n_c_lim = {1'b0, r_b_cd};
            end
            default: begin
                n_c_rr  = 1'b1;
                n_c_mx  = '0;
                n_c_my  = '0;
                n_c_lim = '0;
            end
        endcase
    end

    logic [MagW-1:0]      r_c_mx, r_c_my;
    logic [LimW-1:0]      r_c_lim;
    logic                 r_c_rr, r_c_rrhit;
    logic [AddrWidth-1:0] r_c_addr;

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_mx    <= n_c_mx;
            r_c_my    <= n_c_my;
            r_c_lim   <= n_c_lim;
            r_c_rr    <= n_c_rr;
            r_c_rrhit <= n_c_rrhit;
            r_c_addr  <= r_b_addr;
        end
    end

    // ------------------------------------------------------------------
    // C to D: three independent squarers. The touching bit of the pair
    // is read as the item enters D; if the item leaving D writes the
    // same pair at that edge, its new bit is forwarded instead.
    // ------------------------------------------------------------------
    logic [SqW-1:0]       r_d_sqx, r_d_sqy;
    logic [SqLimW-1:0]    r_d_sql;
    logic                 r_d_rr, r_d_rrhit;
    logic [AddrWidth-1:0] r_d_addr;
    logic                 r_d_fwd, r_d_fwd_val;

    logic [SqW:0]         d_sum;
    logic                 d_hit;
    logic                 d_touched;
    logic                 mem_rd_data;
    logic [1:0]           d_event;

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_sqx     <= SqW'(r_c_mx) * SqW'(r_c_mx);
            r_d_sqy     <= SqW'(r_c_my) * SqW'(r_c_my);
            r_d_sql     <= SqLimW'(r_c_lim) * SqLimW'(r_c_lim);
            r_d_rr      <= r_c_rr;
            r_d_rrhit   <= r_c_rrhit;
            r_d_addr    <= r_c_addr;
            r_d_fwd     <= r_d_valid && (r_c_addr == r_d_addr);
            r_d_fwd_val <= d_hit;
        end
    end

    // ------------------------------------------------------------------
    // D to E: final compare and the contact event.
    // ------------------------------------------------------------------
    always_comb begin
        d_sum     = {1'b0, r_d_sqx} + {1'b0, r_d_sqy};
        d_hit     = r_d_rr ? r_d_rrhit : (d_sum <= (SqW+1)'(r_d_sql));
        d_touched = r_d_fwd ? r_d_fwd_val : mem_rd_data;
        if (d_hit) begin
            d_event = d_touched ? cpct_pkg::EV_STAY : cpct_pkg::EV_ENTER;
        end else begin
            d_event = d_touched ? cpct_pkg::EV_EXIT : cpct_pkg::EV_NONE;
        end
    end

    cpct_touch_mem #(
        .MAX_COLLIDERS (MAX_COLLIDERS)
    ) u_touch_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (en_d),
        .i_rd_addr (r_c_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (r_d_valid && en_e),
        .i_wr_addr (r_d_addr),
        .i_wr_data (d_hit),
        .o_busy    (mem_busy)
    );

    // ------------------------------------------------------------------
    // Stage E: the output register.
    // ------------------------------------------------------------------
    logic       r_e_overlap;
    logic [1:0] r_e_event;

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_overlap <= d_hit;
            r_e_event   <= d_event;
        end
    end

    assign o_m_axis_tvalid = r_e_valid;
    assign o_m_axis_tdata  = {5'b00000, r_e_event, r_e_overlap};

endmodule

`default_nettype wire
